// ----- hdl/lbpw_pkg.sv -----
`timescale 1ns / 1ps

package lbpw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int BUCKETS    = 5;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 20;
    localparam int BUCKET_DIV = 51;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int MDATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic KIND_CODE  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] wm1;
        logic [ROW_W-1:0] hm1;
    } geom_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  bucket;
        logic              eof;
    } item_t;

endpackage

// ----- hdl/lbpw_front.sv -----
`timescale 1ns / 1ps

module lbpw_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  lbpw_pkg::geom_t              geom,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lbpw_pkg::PIX_W-1:0]   s_tdata,    // [7:0] pixel
    input  logic [lbpw_pkg::QCNT_W-1:0]  q_count,
    output logic                         q_push,
    output lbpw_pkg::item_t              q_item
);
    import lbpw_pkg::*;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];   // {upper, middle}

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [2*PIX_W-1:0] rd_reg;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_emit_reg;
    logic               s1_eof_reg;
    logic [PIX_W-1:0]   win_reg [9];
    logic [PIX_W-1:0]   win_next [9];
    logic [PIX_W-1:0]   nb [8];
    logic [CODE_W-1:0]  code;
    logic [IDX_W-1:0]   bucket;
    logic [QCNT_W:0]    occ;
    logic               accept;
    logic               eof;

    assign occ      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg);
    assign s_tready = occ < (QCNT_W+1)'(QDEPTH);
    assign accept   = s_tvalid && s_tready;
    assign eof      = (col_reg == geom.wm1) && (row_reg == geom.hm1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (eof) begin
                col_next = '0;
                row_next = '0;
            end else if (col_reg == geom.wm1) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg      <= line_mem[col_reg];
            s1_pix_reg  <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_eof_reg  <= eof;
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {rd_reg[PIX_W-1:0], s1_pix_reg};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i*3+0] = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = rd_reg[2*PIX_W-1:PIX_W];
        win_next[5] = rd_reg[PIX_W-1:0];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // up-left, up, up-right, left, right, down-left, down, down-right
    always_comb begin
        nb[0] = win_next[0];
        nb[1] = win_next[1];
        nb[2] = win_next[2];
        nb[3] = win_next[3];
        nb[4] = win_next[5];
        nb[5] = win_next[6];
        nb[6] = win_next[7];
        nb[7] = win_next[8];
        for (int b = 0; b < CODE_W; b++) begin
            code[b] = nb[b] >= win_next[4];
        end
    end

    always_comb begin
        priority if (code >= CODE_W'(4*BUCKET_DIV)) bucket = IDX_W'(4);
        else if (code >= CODE_W'(3*BUCKET_DIV))     bucket = IDX_W'(3);
        else if (code >= CODE_W'(2*BUCKET_DIV))     bucket = IDX_W'(2);
        else if (code >= CODE_W'(BUCKET_DIV))       bucket = IDX_W'(1);
        else                                        bucket = IDX_W'(0);
    end

    assign q_push        = s1_valid_reg && s1_emit_reg;
    assign q_item.code   = code;
    assign q_item.bucket = bucket;
    assign q_item.eof    = s1_eof_reg;

endmodule

// ----- hdl/lbpw_fifo.sv -----
`timescale 1ns / 1ps

module lbpw_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  lbpw_pkg::item_t              push_item,
    input  logic                         pop,
    output lbpw_pkg::item_t              head,
    output logic [lbpw_pkg::QCNT_W-1:0]  count
);
    import lbpw_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head  = mem_reg[rd_reg];
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/lbpw_back.sv -----
`timescale 1ns / 1ps

module lbpw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  lbpw_pkg::item_t               q_head,
    input  logic                          q_nonempty,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lbpw_pkg::MDATA_W-1:0]  m_tdata,   // [7:0] pattern_code, [10:8] bucket_index,
                                                     // [30:11] bucket_count, [31] zero
    output logic [0:0]                    m_tuser,   // [0] kind
    output logic                          m_tlast
);
    import lbpw_pkg::*;

    typedef enum logic [1:0] {
        ST_CODE = 2'b01,
        ST_DUMP = 2'b10
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg [BUCKETS];
    logic [CNT_W-1:0]  cnt_next [BUCKETS];
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;
    logic              load;

    assign load  = !out_valid_reg || m_tready;
    assign q_pop = (state_reg == ST_CODE) && q_nonempty && load;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = load ? 1'b0 : out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_code_next  = out_code_reg;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_CODE: begin
                if (q_pop) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CODE;
                    out_code_next  = q_head.code;
                    out_idx_next   = '0;
                    out_cnt_next   = '0;
                    out_last_next  = !q_head.eof;
                    for (int i = 0; i < BUCKETS; i++) begin
                        if (q_head.bucket == IDX_W'(i) && cnt_reg[i] != {CNT_W{1'b1}}) begin
                            cnt_next[i] = cnt_reg[i] + CNT_W'(1);
                        end
                    end
                    if (q_head.eof) begin
                        state_next = ST_DUMP;
                        idx_next   = '0;
                    end
                end
            end
            ST_DUMP: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_COUNT;
                    out_code_next  = '0;
                    out_idx_next   = idx_reg;
                    out_cnt_next   = cnt_reg[idx_reg];
                    out_last_next  = idx_reg == IDX_W'(BUCKETS - 1);
                    if (idx_reg == IDX_W'(BUCKETS - 1)) begin
                        state_next = ST_CODE;
                        for (int i = 0; i < BUCKETS; i++) begin
                            cnt_next[i] = '0;
                        end
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_CODE;
            end
        endcase
        if (restart) begin
            for (int i = 0; i < BUCKETS; i++) begin
                cnt_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CODE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_code_reg <= out_code_next;
        out_idx_reg  <= out_idx_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MDATA_W'({out_cnt_reg, out_idx_reg, out_code_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/lbp_window_histogram_top.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// s_      | in  | s_tvalid / s_tready | s_tdata[7:0] pixel
// m_      | out | m_tvalid / m_tready | m_tdata code/index/count, m_tuser kind, m_tlast
// cfg_    | in  | cfg_we              | cfg_addr register index, cfg_wdata value
//
// One pixel per clock while the queue has room. A pixel reads the line memory into a
// read register when it is taken, its code is formed from that register and enters a
// 4-entry queue, and the output register loads it from the queue head. The frame's
// last pixel holds the back end for six beats (code plus five bucket counts) while the
// front keeps taking pixels until the queue fills. Reset (aresetn low, synchronous)
// clears position, counters and handshake state; line memory contents are not cleared.

module lbp_window_histogram_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lbpw_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lbpw_pkg::MDATA_W-1:0]      m_tdata,   // [7:0] pattern_code, [10:8] bucket_index,
                                                         // [30:11] bucket_count, [31] zero
    output logic [0:0]                        m_tuser,   // [0] kind
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lbpw_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [lbpw_pkg::CFG_W-1:0]        cfg_wdata
);
    import lbpw_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  w_clamp;
    logic [CFG_W-1:0]  h_clamp;
    geom_t             geom;
    logic              restart;
    logic              q_push;
    logic              q_pop;
    item_t             q_item;
    item_t             q_head;
    logic [QCNT_W-1:0] q_count;

    assign restart = cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end else if (cfg_we) begin
            if (cfg_addr == REG_FRAME_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_FRAME_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        priority if (width_reg < CFG_W'(MIN_DIM))  w_clamp = CFG_W'(MIN_DIM);
        else if (width_reg > CFG_W'(MAX_WIDTH))    w_clamp = CFG_W'(MAX_WIDTH);
        else                                       w_clamp = width_reg;
        priority if (height_reg < CFG_W'(MIN_DIM)) h_clamp = CFG_W'(MIN_DIM);
        else if (height_reg > CFG_W'(MAX_HEIGHT))  h_clamp = CFG_W'(MAX_HEIGHT);
        else                                       h_clamp = height_reg;
        geom.wm1 = COL_W'(w_clamp - CFG_W'(1));
        geom.hm1 = ROW_W'(h_clamp - CFG_W'(1));
    end

    lbpw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .geom     (geom),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    lbpw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    lbpw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .q_head     (q_head),
        .q_nonempty (q_count != '0),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && !q_pop |-> q_count != QCNT_W'(QDEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_count != '0)
        else $error("queue underflow");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> q_count < QCNT_W'(QDEPTH))
        else $error("input taken with full queue");

    a_last_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser[0] == KIND_COUNT |->
            m_tdata[CODE_W+IDX_W-1:CODE_W] == IDX_W'(BUCKETS - 1))
        else $error("last count beat not on final bucket");

endmodule

// ----- verif/tb_lbp_window_histogram_top.sv -----
`timescale 1ns / 1ps

module tb_lbp_window_histogram_top;
    import lbpw_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 40;
    localparam int MAX_REPORTS   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum int {PIX_UNIFORM, PIX_NARROW, PIX_EXTREME, PIX_FLAT} pix_style_t;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  bucket;
        logic [CNT_W-1:0]  count;
        logic              last;
    } lbp_beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // shadow of the block
    logic [CFG_W-1:0]  frame_w_reg = CFG_W'(640);
    logic [CFG_W-1:0]  frame_h_reg = CFG_W'(480);
    logic [PIX_W-1:0]  row_upper  [MAX_WIDTH];
    logic [PIX_W-1:0]  row_middle [MAX_WIDTH];
    logic [PIX_W-1:0]  win [9];
    int                col_pos = 0;
    int                row_pos = 0;
    logic [CNT_W-1:0]  bucket_tally [BUCKETS];
    lbp_beat_t         beats_due [$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int fail_count   = 0;
    int pixels_sent  = 0;
    int frames_done  = 0;
    int codes_seen   = 0;
    int counts_seen  = 0;

    lbp_window_histogram_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= !(sink_idle_en && $urandom_range(0, 99) < 17);
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_pixels();
        return clamp_dim(frame_w_reg, MAX_WIDTH) * clamp_dim(frame_h_reg, MAX_HEIGHT);
    endfunction

    function automatic logic [PIX_W-1:0] gen_pixel(input pix_style_t style,
                                                   input logic [PIX_W-1:0] flat_val);
        case (style)
            PIX_NARROW:  return PIX_W'(126 + $urandom_range(0, 3));
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_FLAT:    return flat_val;
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] boundary_code();
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd50;
            2:       return 8'd51;
            3:       return 8'd101;
            4:       return 8'd102;
            5:       return 8'd152;
            6:       return 8'd153;
            7:       return 8'd203;
            8:       return 8'd204;
            9:       return 8'd254;
            10:      return 8'd255;
            default: return CODE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic clear_frame_pos();
        int i;
        col_pos = 0;
        row_pos = 0;
        for (i = 0; i < BUCKETS; i++) bucket_tally[i] = '0;
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        if (idx == REG_FRAME_WIDTH) begin
            frame_w_reg = val;
        end else if (idx == REG_FRAME_HEIGHT) begin
            frame_h_reg = val;
        end else begin
            return;
        end
        clear_frame_pos();
    endtask

    // window shift, line store update, code and bucket results for one pixel
    task automatic apply_pixel(input logic [PIX_W-1:0] px);
        int w, h, c, r, i, b, bkt;
        logic [PIX_W-1:0]  up, mid, centre;
        logic [CODE_W-1:0] code;
        bit eof;
        lbp_beat_t beat;
        w = clamp_dim(frame_w_reg, MAX_WIDTH);
        h = clamp_dim(frame_h_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        up  = row_upper[c];
        mid = row_middle[c];
        for (i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        row_upper[c]  = mid;
        row_middle[c] = px;
        eof = (c == w - 1) && (r == h - 1);
        if (r >= 2 && c >= 2) begin
            centre = win[4];
            code = '0;
            for (b = 0; b < 8; b++)
                if (win[(b < 4) ? b : b + 1] >= centre) code[b] = 1'b1;
            bkt = code / BUCKET_DIV;
            if (bkt > BUCKETS - 1) bkt = BUCKETS - 1;
            if (bucket_tally[bkt] != {CNT_W{1'b1}}) bucket_tally[bkt]++;
            beat.kind   = KIND_CODE;
            beat.code   = code;
            beat.bucket = '0;
            beat.count  = '0;
            beat.last   = !eof;
            beats_due.push_back(beat);
        end
        if (eof) begin
            for (i = 0; i < BUCKETS; i++) begin
                beat.kind   = KIND_COUNT;
                beat.code   = '0;
                beat.bucket = IDX_W'(i);
                beat.count  = bucket_tally[i];
                beat.last   = (i == BUCKETS - 1);
                beats_due.push_back(beat);
            end
            clear_frame_pos();
            frames_done++;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        @(negedge aclk);
        if (src_idle_en && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 2);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_frame(input pix_style_t style, input int n);
        logic [PIX_W-1:0] flat_val;
        int i;
        flat_val = PIX_W'($urandom_range(0, 255));
        for (i = 0; i < n; i++) send_pixel(gen_pixel(style, flat_val));
    endtask

    // 3x3 frame whose single window gives the requested code
    task automatic send_coded_frame(input logic [CODE_W-1:0] code);
        int pos, b;
        logic [PIX_W-1:0] centre;
        centre = PIX_W'($urandom_range(1, 254));
        for (pos = 0; pos < 9; pos++) begin
            b = (pos < 4) ? pos : pos - 1;
            if (pos == 4) send_pixel(centre);
            else if (code[b]) send_pixel(PIX_W'($urandom_range(centre, 255)));
            else send_pixel(PIX_W'($urandom_range(0, centre - 1)));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_config(idx, val);
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s expected %0d actual %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_beats
        lbp_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser[0] == KIND_CODE) codes_seen++;
            else counts_seen++;
            if (beats_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result beat with nothing expected: tdata %h", m_tdata);
            end else begin
                want = beats_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
                check_field("pattern_code", 32'(want.code), 32'(m_tdata[7:0]));
                check_field("bucket_index", 32'(want.bucket), 32'(m_tdata[10:8]));
                check_field("bucket_count", 32'(want.count), 32'(m_tdata[30:11]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("lbp_window_histogram_top test failed");
        $finish;
    end

    // reset geometry: part of the first border row, no results
    task automatic test_default_geometry();
        send_frame(PIX_UNIFORM, 20);
    endtask

    task automatic test_directed_windows();
        int i;
        set_geometry(CFG_W'(3), CFG_W'(3));
        send_frame(PIX_FLAT, 0);
        for (i = 0; i < 9; i++) send_pixel(8'h00);
        for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00);
        send_coded_frame(8'd51);
    endtask

    task automatic test_register_effects();
        set_geometry(CFG_W'(5), CFG_W'(4));
        send_frame(PIX_UNIFORM, 10);
        wait_idle();
        cfg_write(REG_SPARE_2, {CFG_W{1'b1}});
        cfg_write(REG_SPARE_3, CFG_W'($urandom_range(0, 2047)));
        send_frame(PIX_NARROW, 10);
        send_frame(PIX_UNIFORM, 7);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, CFG_W'(4));
        send_frame(PIX_UNIFORM, frame_pixels());
    endtask

    task automatic test_dimension_limits();
        set_geometry(CFG_W'(0), CFG_W'(1));
        send_frame(PIX_UNIFORM, frame_pixels());
        set_geometry(CFG_W'(8), CFG_W'(5));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_frame(PIX_UNIFORM, frame_pixels());
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        set_geometry({CFG_W{1'b1}}, CFG_W'(2));
        send_frame(PIX_UNIFORM, 12);
        set_geometry(CFG_W'(3), CFG_W'(1024));
        send_frame(PIX_UNIFORM, 15);
        wait_idle();
        cfg_write(REG_FRAME_HEIGHT, {CFG_W{1'b1}});
        send_frame(PIX_NARROW, 12);
    endtask

    task automatic test_random_frames();
        int start, nframes;
        logic [CFG_W-1:0] w, h;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) < 2) begin
                set_geometry(CFG_W'(3), CFG_W'(3));
                send_coded_frame(boundary_code());
            end else begin
                w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(9, 12))
                                                : CFG_W'($urandom_range(3, 6));
                h = CFG_W'($urandom_range(3, 4));
                set_geometry(w, h);
                nframes = $urandom_range(1, 2);
                repeat (nframes)
                    send_frame(pix_style_t'($urandom_range(0, 3)), frame_pixels());
                if ($urandom_range(0, 3) == 0)
                    send_frame(PIX_UNIFORM, $urandom_range(1, frame_pixels() - 1));
            end
        end
    endtask

    initial begin : main
        int i;
        for (i = 0; i < 9; i++) win[i] = '0;
        clear_frame_pos();
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_default_geometry();
        test_directed_windows();
        test_register_effects();
        test_dimension_limits();
        test_random_frames();

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("covered %0d pixels, %0d full frames, %0d code beats, %0d bucket beats",
                 pixels_sent, frames_done, codes_seen, counts_seen);
        $display("geometries 3x3 to 1024 wide/tall, clamped and ignored writes, restarts");
        if (fail_count == 0) begin
            $display("lbp_window_histogram_top test passed");
        end else begin
            $display("lbp_window_histogram_top test failed");
        end
        $finish;
    end

endmodule
